### sv/tvsd_pkg.sv
// ----------------------------------------------------------------------------
// tvsd_pkg
// Shared types and codes for the tagged value stream decoder: tag classes,
// parser phases, value kinds and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package tvsd_pkg;

   // Tag byte ranges
   localparam logic [7:0] TAG_MSG_HI       = 8'h04;
   localparam logic [7:0] TAG_INT4         = 8'h10;
   localparam logic [7:0] TAG_STR4         = 8'h11;
   localparam logic [7:0] TAG_STR2         = 8'h12;
   localparam logic [7:0] TAG_BUF4         = 8'h13;
   localparam logic [7:0] TAG_BUF2         = 8'h14;
   localparam logic [7:0] TAG_SIMPLE_LO    = 8'h15;
   localparam logic [7:0] TAG_SIMPLE_HI    = 8'h19;
   localparam logic [7:0] TAG_FLOAT        = 8'h1A;
   localparam logic [7:0] TAG_OBJ          = 8'h1B;
   localparam logic [7:0] TAG_PTR          = 8'h1C;
   localparam logic [7:0] TAG_LFUNC        = 8'h1D;
   localparam logic [7:0] TAG_HEAPPTR      = 8'h1E;
   localparam logic [7:0] TAG_SHORT_STR_LO = 8'h60;
   localparam logic [7:0] TAG_SHORT_STR_HI = 8'h7F;
   localparam logic [7:0] TAG_SMALL_INT_LO = 8'h80;
   localparam logic [7:0] TAG_SMALL_INT_HI = 8'hBF;
   localparam logic [7:0] TAG_INT2_LO      = 8'hC0;
   localparam logic [7:0] TAG_INT2_HI      = 8'hFF;

   // Distance from simple tag code to its kind code
   localparam logic [4:0] SIMPLE_KIND_OFFSET = 5'd13;

   // Value kinds
   localparam logic [4:0] K_EOM       = 5'd0;
   localparam logic [4:0] K_INT       = 5'd5;
   localparam logic [4:0] K_STRING    = 5'd6;
   localparam logic [4:0] K_BUFFER    = 5'd7;
   localparam logic [4:0] K_FLOAT     = 5'd13;
   localparam logic [4:0] K_OBJ       = 5'd14;
   localparam logic [4:0] K_PTR       = 5'd15;
   localparam logic [4:0] K_LIGHTFUNC = 5'd16;
   localparam logic [4:0] K_HEAPPTR   = 5'd17;
   localparam logic [4:0] K_UNKNOWN   = 5'd18;

   // Message position and kind codes
   localparam logic [1:0] POS_LEAD   = 2'd0;
   localparam logic [1:0] POS_BODY   = 2'd1;
   localparam logic [1:0] POS_END    = 2'd2;
   localparam logic [2:0] MK_UNKNOWN = 3'd0;

   // Field lengths in bytes
   localparam logic [31:0] LEN_LONG  = 32'd4;
   localparam logic [31:0] LEN_SHORT = 32'd2;
   localparam logic [31:0] LEN_FLOAT = 32'd8;
   localparam logic [31:0] LEN_FLAGS = 32'd2;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      TC_MSG, TC_INT4, TC_STR4, TC_STR2, TC_BUF4, TC_BUF2, TC_FLOAT, TC_OBJ,
      TC_PTR, TC_LFUNC, TC_HEAPPTR, TC_SIMPLE, TC_SHORTSTR, TC_SMALLINT,
      TC_INT2, TC_UNKNOWN
   } tag_class_type;

   typedef enum logic [3:0] {
      PH_TAG, PH_INT4, PH_INT2, PH_LEN, PH_PAYLOAD, PH_FLOAT, PH_CLASS,
      PH_FLAGS, PH_PSIZE, PH_PDATA
   } phase_type;

   typedef struct packed {
      logic [7:0]    data;
      tag_class_type tclass;
      logic [4:0]    kind;
   } qentry_type;

endpackage

### sv/tvsd_front.sv
// ----------------------------------------------------------------------------
// tvsd_front
// Classifies each incoming byte as a tag and derives the value kind it
// would start; the back end uses this only when it expects a tag.
// ----------------------------------------------------------------------------
module tvsd_front
   import tvsd_pkg::*;
(
   input  logic [7:0] in_byte,
   output qentry_type entry
);

   always_comb begin
      entry.data   = in_byte;
      entry.tclass = TC_UNKNOWN;
      entry.kind   = K_UNKNOWN;
      unique case (in_byte) inside
         [8'h00:TAG_MSG_HI]: begin
            entry.tclass = TC_MSG;
            entry.kind   = in_byte[4:0];
         end
         TAG_INT4: begin
            entry.tclass = TC_INT4;
            entry.kind   = K_INT;
         end
         TAG_STR4: begin
            entry.tclass = TC_STR4;
            entry.kind   = K_STRING;
         end
         TAG_STR2: begin
            entry.tclass = TC_STR2;
            entry.kind   = K_STRING;
         end
         TAG_BUF4: begin
            entry.tclass = TC_BUF4;
            entry.kind   = K_BUFFER;
         end
         TAG_BUF2: begin
            entry.tclass = TC_BUF2;
            entry.kind   = K_BUFFER;
         end
         [TAG_SIMPLE_LO:TAG_SIMPLE_HI]: begin
            entry.tclass = TC_SIMPLE;
            entry.kind   = in_byte[4:0] - SIMPLE_KIND_OFFSET;
         end
         TAG_FLOAT: begin
            entry.tclass = TC_FLOAT;
            entry.kind   = K_FLOAT;
         end
         TAG_OBJ: begin
            entry.tclass = TC_OBJ;
            entry.kind   = K_OBJ;
         end
         TAG_PTR: begin
            entry.tclass = TC_PTR;
            entry.kind   = K_PTR;
         end
         TAG_LFUNC: begin
            entry.tclass = TC_LFUNC;
            entry.kind   = K_LIGHTFUNC;
         end
         TAG_HEAPPTR: begin
            entry.tclass = TC_HEAPPTR;
            entry.kind   = K_HEAPPTR;
         end
         [TAG_SHORT_STR_LO:TAG_SHORT_STR_HI]: begin
            entry.tclass = TC_SHORTSTR;
            entry.kind   = K_STRING;
         end
         [TAG_SMALL_INT_LO:TAG_SMALL_INT_HI]: begin
            entry.tclass = TC_SMALLINT;
            entry.kind   = K_INT;
         end
         [TAG_INT2_LO:TAG_INT2_HI]: begin
            entry.tclass = TC_INT2;
            entry.kind   = K_INT;
         end
         default: begin
            entry.tclass = TC_UNKNOWN;
            entry.kind   = K_UNKNOWN;
         end
      endcase
   end

endmodule

### sv/tvsd_queue.sv
// ----------------------------------------------------------------------------
// tvsd_queue
// Short FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module tvsd_queue
   import tvsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output qentry_type head_entry
);

   qentry_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
      if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
`endif

endmodule

### sv/tvsd_back.sv
// ----------------------------------------------------------------------------
// tvsd_back
// Value parser: consumes classified requests, tracks framing and builds
// at most one header or payload result per request into the output register.
// ----------------------------------------------------------------------------
module tvsd_back
   import tvsd_pkg::*;
#(
   parameter int MAX_POINTER_BYTES = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  qentry_type         q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_value_kind,
   output logic signed [31:0] rsp_int_result,
   output logic [31:0]        rsp_payload_length,
   output logic [63:0]        rsp_pointer_address,
   output logic [7:0]         rsp_pointer_bytes,
   output logic [7:0]         rsp_object_class,
   output logic [63:0]        rsp_float_bits,
   output logic [7:0]         rsp_payload_byte,
   output logic               rsp_is_payload,
   output logic               rsp_last_of_value,
   output logic [1:0]         rsp_message_position,
   output logic [2:0]         rsp_message_kind
);

   localparam int          ADDR_BITS = 8 * MAX_POINTER_BYTES;
   localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

   phase_type   phase_ff, phase_in;
   logic [4:0]  kind_ff, kind_in;
   logic [31:0] left_ff, left_in;
   logic [63:0] shift_ff, shift_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  psize_ff, psize_in;
   logic        expect_ff, expect_in;
   logic [2:0]  mkind_ff, mkind_in;
   logic        lead_ff, lead_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic               emit;
   logic [4:0]         r_kind;
   logic signed [31:0] r_int;
   logic [31:0]        r_len;
   logic [63:0]        r_addr;
   logic [63:0]        r_fbits;
   logic [7:0]         r_pbyte;
   logic               r_isp;
   logic               r_last;
   logic [7:0]         r_ptr_bytes;
   logic [7:0]         r_class;
   logic [1:0]         r_pos;

   logic [4:0]         kind_out_ff;
   logic signed [31:0] int_out_ff;
   logic [31:0]        len_out_ff;
   logic [63:0]        addr_out_ff;
   logic [7:0]         psize_out_ff;
   logic [7:0]         class_out_ff;
   logic [63:0]        fbits_out_ff;
   logic [7:0]         pbyte_out_ff;
   logic               isp_out_ff;
   logic               last_out_ff;
   logic [1:0]         pos_out_ff;
   logic [2:0]         mkind_out_ff;

   logic [7:0]  b;
   logic [31:0] left_dec;
   logic [63:0] shift8;
   logic        pop;
   logic        is_ptr_kind;

   assign b        = q_entry.data;
   assign pop      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop    = pop;
   assign left_dec = (left_ff != '0) ? left_ff - 32'd1 : '0;
   assign shift8   = {shift_ff[55:0], b};

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      left_in   = left_ff;
      shift_in  = shift_ff;
      class_in  = class_ff;
      psize_in  = psize_ff;
      expect_in = expect_ff;
      mkind_in  = mkind_ff;
      lead_in   = lead_ff;
      emit      = 1'b0;
      r_kind    = K_EOM;
      r_int     = '0;
      r_len     = '0;
      r_addr    = '0;
      r_fbits   = '0;
      r_pbyte   = '0;
      r_isp     = 1'b0;
      r_last    = 1'b0;

      unique case (phase_ff) inside
         PH_TAG: begin
            lead_in = expect_ff;
            if (expect_ff) begin
               expect_in = 1'b0;
               mkind_in  = (q_entry.tclass == TC_MSG && b != 8'h00) ? b[2:0] : MK_UNKNOWN;
            end
            shift_in = '0;
            class_in = '0;
            psize_in = '0;
            left_in  = '0;
            kind_in  = q_entry.kind;
            unique case (q_entry.tclass) inside
               TC_MSG, TC_SIMPLE, TC_UNKNOWN: begin
                  emit   = 1'b1;
                  r_kind = q_entry.kind;
                  r_last = 1'b1;
               end
               TC_INT4: begin
                  phase_in = PH_INT4;
                  left_in  = LEN_LONG;
               end
               TC_STR4, TC_BUF4: begin
                  phase_in = PH_LEN;
                  left_in  = LEN_LONG;
               end
               TC_STR2, TC_BUF2: begin
                  phase_in = PH_LEN;
                  left_in  = LEN_SHORT;
               end
               TC_FLOAT: begin
                  phase_in = PH_FLOAT;
                  left_in  = LEN_FLOAT;
               end
               TC_OBJ: begin
                  phase_in = PH_CLASS;
               end
               TC_PTR, TC_HEAPPTR: begin
                  phase_in = PH_PSIZE;
               end
               TC_LFUNC: begin
                  phase_in = PH_FLAGS;
                  left_in  = LEN_FLAGS;
               end
               TC_SHORTSTR: begin
                  emit   = 1'b1;
                  r_kind = q_entry.kind;
                  if (b[4:0] == 5'd0) begin
                     r_last = 1'b1;
                  end else begin
                     r_len    = {27'd0, b[4:0]};
                     left_in  = {27'd0, b[4:0]};
                     phase_in = PH_PAYLOAD;
                  end
               end
               TC_SMALLINT: begin
                  emit   = 1'b1;
                  r_kind = K_INT;
                  r_int  = {26'd0, b[5:0]};
                  r_last = 1'b1;
               end
               TC_INT2: begin
                  shift_in = {58'd0, b[5:0]};
                  phase_in = PH_INT2;
               end
               default: begin
                  emit   = 1'b1;
                  r_kind = K_UNKNOWN;
                  r_last = 1'b1;
               end
            endcase
         end
         PH_INT4, PH_LEN, PH_FLOAT: begin
            shift_in = shift8;
            left_in  = left_dec;
            if (left_dec == '0) begin
               emit = 1'b1;
               if (phase_ff == PH_INT4) begin
                  r_kind = K_INT;
                  r_int  = shift8[31:0];
                  r_last = 1'b1;
               end else if (phase_ff == PH_FLOAT) begin
                  r_kind  = K_FLOAT;
                  r_fbits = shift8;
                  r_last  = 1'b1;
               end else begin
                  r_kind = kind_ff;
                  if (shift8[31:0] == '0) begin
                     r_last = 1'b1;
                  end else begin
                     r_len    = shift8[31:0];
                     left_in  = shift8[31:0];
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_INT2: begin
            emit   = 1'b1;
            r_kind = K_INT;
            r_int  = {18'd0, shift_ff[5:0], b};
            r_last = 1'b1;
         end
         PH_PAYLOAD: begin
            left_in = left_dec;
            emit    = 1'b1;
            r_kind  = kind_ff;
            r_pbyte = b;
            r_isp   = 1'b1;
            r_last  = (left_dec == '0);
         end
         PH_CLASS: begin
            class_in = b;
            phase_in = PH_PSIZE;
         end
         PH_FLAGS: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_PSIZE;
            end
         end
         PH_PSIZE: begin
            psize_in = b;
            shift_in = '0;
            if (b == 8'h00) begin
               emit   = 1'b1;
               r_kind = kind_ff;
               r_last = 1'b1;
            end else begin
               left_in  = {24'd0, b};
               phase_in = PH_PDATA;
            end
         end
         PH_PDATA: begin
            shift_in = shift8 & ADDR_MASK;
            left_in  = left_dec;
            if (left_dec == '0) begin
               emit   = 1'b1;
               r_kind = kind_ff;
               r_addr = shift8 & ADDR_MASK;
               r_last = 1'b1;
            end
         end
         default: begin
            phase_in = PH_TAG;
         end
      endcase

      // close the value; an end marker in body position reopens framing
      if (emit && r_last) begin
         phase_in = PH_TAG;
         if (!lead_in && r_kind == K_EOM) begin
            expect_in = 1'b1;
         end
      end

      is_ptr_kind = (r_kind >= K_OBJ) && (r_kind <= K_HEAPPTR) && !r_isp;
      r_ptr_bytes = is_ptr_kind ? psize_in : '0;
      r_class     = (r_kind == K_OBJ && !r_isp) ? class_in : '0;
      if (lead_in) begin
         r_pos = POS_LEAD;
      end else if (r_kind == K_EOM) begin
         r_pos = POS_END;
      end else begin
         r_pos = POS_BODY;
      end

      rsp_valid_in = rsp_valid_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         kind_ff      <= '0;
         left_ff      <= '0;
         shift_ff     <= '0;
         class_ff     <= '0;
         psize_ff     <= '0;
         expect_ff    <= 1'b1;
         mkind_ff     <= MK_UNKNOWN;
         lead_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff  <= phase_in;
            kind_ff   <= kind_in;
            left_ff   <= left_in;
            shift_ff  <= shift_in;
            class_ff  <= class_in;
            psize_ff  <= psize_in;
            expect_ff <= expect_in;
            mkind_ff  <= mkind_in;
            lead_ff   <= lead_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_out_ff  <= r_kind;
         int_out_ff   <= r_int;
         len_out_ff   <= r_len;
         addr_out_ff  <= r_addr;
         psize_out_ff <= r_ptr_bytes;
         class_out_ff <= r_class;
         fbits_out_ff <= r_fbits;
         pbyte_out_ff <= r_pbyte;
         isp_out_ff   <= r_isp;
         last_out_ff  <= r_last;
         pos_out_ff   <= r_pos;
         mkind_out_ff <= mkind_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_value_kind       = kind_out_ff;
   assign rsp_int_result       = int_out_ff;
   assign rsp_payload_length   = len_out_ff;
   assign rsp_pointer_address  = addr_out_ff;
   assign rsp_pointer_bytes    = psize_out_ff;
   assign rsp_object_class     = class_out_ff;
   assign rsp_float_bits       = fbits_out_ff;
   assign rsp_payload_byte     = pbyte_out_ff;
   assign rsp_is_payload       = isp_out_ff;
   assign rsp_last_of_value    = last_out_ff;
   assign rsp_message_position = pos_out_ff;
   assign rsp_message_kind     = mkind_out_ff;

`ifndef SYNTHESIS
   a_reset_state: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_TAG) && expect_ff && !rsp_valid_ff)
      else $error("parser not at tag phase after reset");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != '0))
      else $error("payload phase with no bytes left");

   a_payload_continue: assert property (@(posedge clock) disable iff (reset)
      (pop && emit && r_isp && !r_last) |=> (phase_ff == PH_PAYLOAD))
      else $error("payload ended before its last byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("result register overwritten while stalled");
`endif

endmodule

### sv/tagged_value_stream_decoder.sv
// ----------------------------------------------------------------------------
// tagged_value_stream_decoder
// Debug-link tagged value decoder: byte stream in, value headers and
// payload bytes out.
// ----------------------------------------------------------------------------
// Takes one link byte per request and returns at most one result per byte:
// a header when a value's fields are complete, then one result per string or
// buffer payload byte. A byte is accepted every cycle while the queue is not
// full; the front classifies it and writes it into a two-entry queue, and the
// parser consumes one queue entry per cycle whenever its output register is
// empty or being drained, and registers each result in that output register.
// The parser update (one 32-bit count decrement and a byte shift into the
// 64-bit value register) sets the rate. req_stall rises only when the queue
// fills because rsp_stall holds the output register.
module tagged_value_stream_decoder
   import tvsd_pkg::*;
#(
   parameter int MAX_POINTER_BYTES = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_value_kind,
   output logic signed [31:0] rsp_int_result,
   output logic [31:0]        rsp_payload_length,
   output logic [63:0]        rsp_pointer_address,
   output logic [7:0]         rsp_pointer_bytes,
   output logic [7:0]         rsp_object_class,
   output logic [63:0]        rsp_float_bits,
   output logic [7:0]         rsp_payload_byte,
   output logic               rsp_is_payload,
   output logic               rsp_last_of_value,
   output logic [1:0]         rsp_message_position,
   output logic [2:0]         rsp_message_kind
);

   qentry_type front_entry;
   qentry_type head_entry;
   logic       q_valid;
   logic       q_full;
   logic       q_pop;
   logic       push;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   tvsd_front u_front (
      .in_byte (req_in_byte),
      .entry   (front_entry)
   );

   tvsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   tvsd_back #(
      .MAX_POINTER_BYTES (MAX_POINTER_BYTES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_entry              (head_entry),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_value_kind       (rsp_value_kind),
      .rsp_int_result       (rsp_int_result),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_pointer_address  (rsp_pointer_address),
      .rsp_pointer_bytes    (rsp_pointer_bytes),
      .rsp_object_class     (rsp_object_class),
      .rsp_float_bits       (rsp_float_bits),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_is_payload       (rsp_is_payload),
      .rsp_last_of_value    (rsp_last_of_value),
      .rsp_message_position (rsp_message_position),
      .rsp_message_kind     (rsp_message_kind)
   );

endmodule

### dv/tagged_value_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// tagged_value_stream_decoder_tb
// Self-checking bench for the tagged value stream decoder. A short table of
// link bytes hits the field extremes and the odd cases: end marker as lead,
// unknown tag, empty string, zero-size and over-long pointers. Random
// messages follow, with tags and lengths picked from the parser state. Every
// byte runs through an in-bench decoder, and each result is compared field
// by field in order. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tagged_value_stream_decoder_tb;
   import tvsd_pkg::*;

   localparam int PTR_BYTES      = 8;
   localparam int ITEMS_PER_LOAD = 125;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 200000;
   localparam logic [63:0] ADDR_KEEP =
      (PTR_BYTES >= 8) ? '1 : ((64'd1 << (8 * PTR_BYTES)) - 64'd1);

   // Codes the package leaves out
   localparam logic [7:0] TAG_EOM           = 8'h00;
   localparam logic [7:0] TAG_REQ           = 8'h01;
   localparam logic [7:0] TAG_UNKNOWN_LO    = 8'h05;
   localparam logic [7:0] TAG_UNKNOWN_LO_HI = 8'h0F;
   localparam logic [7:0] TAG_UNKNOWN_HI_LO = 8'h1F;
   localparam logic [7:0] TAG_UNKNOWN_HI    = 8'h5F;
   localparam logic [4:0] K_REQ             = 5'd1;
   localparam logic [4:0] K_UNUSED          = 5'd8;
   localparam logic [2:0] MK_REQUEST        = 3'd1;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] int_result;
      logic [31:0] payload_len;
      logic [63:0] address;
      logic [7:0]  ptr_bytes;
      logic [7:0]  obj_class;
      logic [63:0] float_bits;
      logic [7:0]  pay_byte;
      logic        is_payload;
      logic        last;
      logic [1:0]  position;
      logic [2:0]  msg_kind;
   } decoded_type;

   typedef struct packed {
      logic [7:0]  in_byte;
      logic        pinned;
      decoded_type want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_in_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [4:0]         rsp_value_kind;
   logic signed [31:0] rsp_int_result;
   logic [31:0]        rsp_payload_length;
   logic [63:0]        rsp_pointer_address;
   logic [7:0]         rsp_pointer_bytes;
   logic [7:0]         rsp_object_class;
   logic [63:0]        rsp_float_bits;
   logic [7:0]         rsp_payload_byte;
   logic               rsp_is_payload;
   logic               rsp_last_of_value;
   logic [1:0]         rsp_message_position;
   logic [2:0]         rsp_message_kind;

   // Decoder state mirrored in the bench
   phase_type   phase_q;
   logic [4:0]  kind_q;
   logic [31:0] left_q;
   logic [63:0] shift_q;
   logic [7:0]  class_q;
   logic [7:0]  ptr_size_q;
   logic        want_lead_q;
   logic [2:0]  msg_kind_q;
   logic        is_lead_q;

   decoded_type  pending_values[$];
   stim_row_type directed_rows[$];
   logic         pin_active;
   decoded_type  pin_want;
   int           idle_pct;
   int           stall_pct;
   int           failures;
   int           cycle_count;
   int           bytes_sent;
   int           results_checked;
   int           messages_closed;
   int           payload_seen;
   bit [18:0]    kinds_seen;

   tagged_value_stream_decoder #(
      .MAX_POINTER_BYTES (PTR_BYTES)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_in_byte          (req_in_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_value_kind       (rsp_value_kind),
      .rsp_int_result       (rsp_int_result),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_pointer_address  (rsp_pointer_address),
      .rsp_pointer_bytes    (rsp_pointer_bytes),
      .rsp_object_class     (rsp_object_class),
      .rsp_float_bits       (rsp_float_bits),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_is_payload       (rsp_is_payload),
      .rsp_last_of_value    (rsp_last_of_value),
      .rsp_message_position (rsp_message_position),
      .rsp_message_kind     (rsp_message_kind)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void reset_decoder();
      phase_q     = PH_TAG;
      kind_q      = K_EOM;
      left_q      = '0;
      shift_q     = '0;
      class_q     = '0;
      ptr_size_q  = '0;
      want_lead_q = 1'b1;
      msg_kind_q  = MK_UNKNOWN;
      is_lead_q   = 1'b0;
   endfunction

   // Build one result; a closing result returns the parser to the tag phase
   function automatic decoded_type make_result(logic [4:0] kind, logic [31:0] ival,
                                               logic [31:0] len, logic [63:0] addr,
                                               logic [63:0] fbits, logic [7:0] pbyte,
                                               logic isp, logic last);
      decoded_type r;
      r             = '0;
      r.kind        = kind;
      r.int_result  = ival;
      r.payload_len = len;
      if (kind >= K_OBJ && kind <= K_HEAPPTR && !isp) begin
         r.address   = addr;
         r.ptr_bytes = ptr_size_q;
      end
      if (kind == K_OBJ && !isp) r.obj_class = class_q;
      r.float_bits = fbits;
      r.pay_byte   = pbyte;
      r.is_payload = isp;
      r.last       = last;
      r.position   = is_lead_q ? POS_LEAD : (kind == K_EOM ? POS_END : POS_BODY);
      r.msg_kind   = msg_kind_q;
      if (last) begin
         phase_q = PH_TAG;
         if (!is_lead_q && kind == K_EOM) want_lead_q = 1'b1;
      end
      return r;
   endfunction

   function automatic decoded_type open_payload(logic [31:0] len);
      decoded_type r;
      if (len == 0) return make_result(kind_q, '0, '0, '0, '0, '0, 1'b0, 1'b1);
      left_q  = len;
      r       = make_result(kind_q, '0, len, '0, '0, '0, 1'b0, 1'b0);
      phase_q = PH_PAYLOAD;
      return r;
   endfunction

   // Advance the parser by one link byte; returns 1 when a result is due
   function automatic bit decode_byte(input logic [7:0] b, output decoded_type r);
      r = '0;
      case (phase_q) inside
         PH_TAG: begin
            is_lead_q = want_lead_q;
            if (want_lead_q) begin
               want_lead_q = 1'b0;
               msg_kind_q  = (b >= TAG_REQ && b <= TAG_MSG_HI) ? b[2:0] : MK_UNKNOWN;
            end
            shift_q    = '0;
            class_q    = '0;
            ptr_size_q = '0;
            left_q     = '0;
            if (b <= TAG_MSG_HI) begin
               kind_q = b[4:0];
               r = make_result(kind_q, '0, '0, '0, '0, '0, 1'b0, 1'b1);
               return 1'b1;
            end
            case (b)
               TAG_INT4: begin
                  kind_q = K_INT; phase_q = PH_INT4; left_q = LEN_LONG; return 1'b0;
               end
               TAG_STR4: begin
                  kind_q = K_STRING; phase_q = PH_LEN; left_q = LEN_LONG; return 1'b0;
               end
               TAG_STR2: begin
                  kind_q = K_STRING; phase_q = PH_LEN; left_q = LEN_SHORT; return 1'b0;
               end
               TAG_BUF4: begin
                  kind_q = K_BUFFER; phase_q = PH_LEN; left_q = LEN_LONG; return 1'b0;
               end
               TAG_BUF2: begin
                  kind_q = K_BUFFER; phase_q = PH_LEN; left_q = LEN_SHORT; return 1'b0;
               end
               TAG_FLOAT: begin
                  kind_q = K_FLOAT; phase_q = PH_FLOAT; left_q = LEN_FLOAT; return 1'b0;
               end
               TAG_OBJ: begin
                  kind_q = K_OBJ; phase_q = PH_CLASS; return 1'b0;
               end
               TAG_PTR: begin
                  kind_q = K_PTR; phase_q = PH_PSIZE; return 1'b0;
               end
               TAG_LFUNC: begin
                  kind_q = K_LIGHTFUNC; phase_q = PH_FLAGS; left_q = LEN_FLAGS;
                  return 1'b0;
               end
               TAG_HEAPPTR: begin
                  kind_q = K_HEAPPTR; phase_q = PH_PSIZE; return 1'b0;
               end
               default: ;
            endcase
            if (b >= TAG_SIMPLE_LO && b <= TAG_SIMPLE_HI) begin
               kind_q = 5'(b - TAG_SIMPLE_LO) + K_UNUSED;
               r = make_result(kind_q, '0, '0, '0, '0, '0, 1'b0, 1'b1);
               return 1'b1;
            end
            if (b >= TAG_SHORT_STR_LO && b <= TAG_SHORT_STR_HI) begin
               kind_q = K_STRING;
               r = open_payload({24'd0, b - TAG_SHORT_STR_LO});
               return 1'b1;
            end
            if (b >= TAG_SMALL_INT_LO && b <= TAG_SMALL_INT_HI) begin
               kind_q = K_INT;
               r = make_result(K_INT, {24'd0, b - TAG_SMALL_INT_LO}, '0, '0, '0, '0,
                               1'b0, 1'b1);
               return 1'b1;
            end
            if (b >= TAG_INT2_LO) begin
               kind_q  = K_INT;
               shift_q = {56'd0, b - TAG_INT2_LO};
               phase_q = PH_INT2;
               return 1'b0;
            end
            kind_q = K_UNKNOWN;
            r = make_result(K_UNKNOWN, '0, '0, '0, '0, '0, 1'b0, 1'b1);
            return 1'b1;
         end
         PH_INT4, PH_LEN, PH_FLOAT: begin
            shift_q = {shift_q[55:0], b};
            if (left_q > 0) left_q = left_q - 1;
            if (left_q != 0) return 1'b0;
            if (phase_q == PH_INT4)
               r = make_result(K_INT, shift_q[31:0], '0, '0, '0, '0, 1'b0, 1'b1);
            else if (phase_q == PH_FLOAT)
               r = make_result(K_FLOAT, '0, '0, '0, shift_q, '0, 1'b0, 1'b1);
            else
               r = open_payload(shift_q[31:0]);
            return 1'b1;
         end
         PH_INT2: begin
            r = make_result(K_INT, {18'd0, shift_q[5:0], b}, '0, '0, '0, '0, 1'b0, 1'b1);
            return 1'b1;
         end
         PH_PAYLOAD: begin
            if (left_q > 0) left_q = left_q - 1;
            r = make_result(kind_q, '0, '0, '0, '0, b, 1'b1, left_q == 0);
            return 1'b1;
         end
         PH_CLASS: begin
            class_q = b;
            phase_q = PH_PSIZE;
            return 1'b0;
         end
         PH_FLAGS: begin
            if (left_q > 0) left_q = left_q - 1;
            if (left_q == 0) phase_q = PH_PSIZE;
            return 1'b0;
         end
         PH_PSIZE: begin
            ptr_size_q = b;
            shift_q    = '0;
            if (b == 0) begin
               r = make_result(kind_q, '0, '0, '0, '0, '0, 1'b0, 1'b1);
               return 1'b1;
            end
            left_q  = {24'd0, b};
            phase_q = PH_PDATA;
            return 1'b0;
         end
         PH_PDATA: begin
            // keep only the trailing address bytes
            shift_q = {shift_q[55:0], b} & ADDR_KEEP;
            if (left_q > 0) left_q = left_q - 1;
            if (left_q != 0) return 1'b0;
            r = make_result(kind_q, '0, '0, shift_q, '0, '0, 1'b0, 1'b1);
            return 1'b1;
         end
         default: begin
            phase_q = PH_TAG;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_value_tag();
      case ($urandom_range(15))
         0:  return TAG_INT4;
         1:  return TAG_STR4;
         2:  return TAG_STR2;
         3:  return TAG_BUF4;
         4:  return TAG_BUF2;
         5:  return 8'($urandom_range(TAG_SIMPLE_LO, TAG_SIMPLE_HI));
         6:  return TAG_FLOAT;
         7:  return TAG_OBJ;
         8:  return TAG_PTR;
         9:  return TAG_LFUNC;
         10: return TAG_HEAPPTR;
         11: return 8'($urandom_range(TAG_SHORT_STR_LO, TAG_SHORT_STR_HI));
         12: return 8'($urandom_range(TAG_SMALL_INT_LO, TAG_SMALL_INT_HI));
         13: return 8'($urandom_range(TAG_INT2_LO, TAG_INT2_HI));
         14: return $urandom_range(1) ?
                    8'($urandom_range(TAG_UNKNOWN_LO, TAG_UNKNOWN_LO_HI)) :
                    8'($urandom_range(TAG_UNKNOWN_HI_LO, TAG_UNKNOWN_HI));
         default: return 8'($urandom_range(TAG_REQ, TAG_MSG_HI));
      endcase
   endfunction

   // Pick the next byte from the parser phase so lengths stay short
   function automatic logic [7:0] pick_next_byte();
      int roll;
      roll = $urandom_range(99);
      case (phase_q)
         PH_TAG: begin
            if (want_lead_q) begin
               if (roll < 80) return 8'($urandom_range(TAG_REQ, TAG_MSG_HI));
               if (roll < 88) return TAG_EOM;
               return pick_value_tag();
            end
            if (roll < 15) return TAG_EOM;
            if (roll < 18) return 8'($urandom_range(255));
            return pick_value_tag();
         end
         PH_LEN: begin
            if (left_q > 2) return 8'd0;
            if (left_q == 2) return (roll < 3) ? 8'd1 : 8'd0;
            return (roll < 85) ? 8'($urandom_range(12)) : 8'($urandom_range(255));
         end
         PH_PSIZE: begin
            if (roll < 80) return 8'($urandom_range(PTR_BYTES));
            if (roll < 95) return 8'($urandom_range(PTR_BYTES + 1, 2 * PTR_BYTES));
            return 8'($urandom_range(2 * PTR_BYTES + 1, 255));
         end
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic stim_row_type plain_row(logic [7:0] b);
      stim_row_type row;
      row         = '0;
      row.in_byte = b;
      return row;
   endfunction

   function automatic stim_row_type pinned_row(logic [7:0] b, logic [4:0] kind,
                                               logic [31:0] ival, logic [31:0] len,
                                               logic [1:0] pos, logic [2:0] mk);
      stim_row_type row;
      row                  = '0;
      row.in_byte          = b;
      row.pinned           = 1'b1;
      row.want.kind        = kind;
      row.want.int_result  = ival;
      row.want.payload_len = len;
      row.want.last        = 1'b1;
      row.want.position    = pos;
      row.want.msg_kind    = mk;
      return row;
   endfunction

   task automatic send_request(input bit from_table, input stim_row_type row);
      int         gap;
      logic [7:0] b;
      gap = 0;
      @(negedge clock);
      while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (from_table) begin
         b          = row.in_byte;
         pin_active = row.pinned;
         pin_want   = row.want;
      end else begin
         b          = pick_next_byte();
         pin_active = 1'b0;
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drop valid and hold until every pending result has drained
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("no progress after %0d cycles, %0d results pending", cycle_count,
                pending_values.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      decoded_type want;
      decoded_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_values.size() == 0) begin
               $error("result with no request pending: kind %0d", rsp_value_kind);
               failures++;
            end else begin
               want = pending_values.pop_front();
               check_field("value_kind", want.kind, rsp_value_kind);
               check_field("int_result", want.int_result, $unsigned(rsp_int_result));
               check_field("payload_length", want.payload_len, rsp_payload_length);
               check_field("pointer_address", want.address, rsp_pointer_address);
               check_field("pointer_bytes", want.ptr_bytes, rsp_pointer_bytes);
               check_field("object_class", want.obj_class, rsp_object_class);
               check_field("float_bits", want.float_bits, rsp_float_bits);
               check_field("payload_byte", want.pay_byte, rsp_payload_byte);
               check_field("is_payload", want.is_payload, rsp_is_payload);
               check_field("last_of_value", want.last, rsp_last_of_value);
               check_field("message_position", want.position, rsp_message_position);
               check_field("message_kind", want.msg_kind, rsp_message_kind);
               results_checked++;
               if (want.kind <= K_UNKNOWN) kinds_seen[want.kind] = 1'b1;
               if (want.position == POS_END) messages_closed++;
               if (want.is_payload) payload_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            bytes_sent++;
            if (decode_byte(req_in_byte, got) && !pin_active) pending_values.push_back(got);
            if (pin_active) pending_values.push_back(pin_want);
         end
      end
   end

   initial begin
      stim_row_type no_row;
      int           idle_load[4];
      int           stall_load[4];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = '0;
      rsp_stall   = 1'b0;
      pin_active  = 1'b0;
      pin_want    = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      failures    = 0;
      cycle_count = 0;
      bytes_sent  = 0;
      results_checked = 0;
      messages_closed = 0;
      payload_seen    = 0;
      kinds_seen      = '0;
      no_row          = '0;
      idle_load  = '{0, 70, 0, 25};
      stall_load = '{0, 0, 70, 25};
      reset_decoder();

      // Request message with integer extremes, then a message led by an end
      // marker holding an unknown tag, an empty string and odd pointers
      directed_rows.push_back(pinned_row(TAG_REQ, K_REQ, '0, '0, POS_LEAD, MK_REQUEST));
      directed_rows.push_back(pinned_row(TAG_SMALL_INT_LO, K_INT, '0, '0, POS_BODY,
                                         MK_REQUEST));
      directed_rows.push_back(pinned_row(TAG_SMALL_INT_HI, K_INT, 32'd63, '0, POS_BODY,
                                         MK_REQUEST));
      directed_rows.push_back(plain_row(TAG_INT2_HI));
      directed_rows.push_back(pinned_row(8'hFF, K_INT, 32'h3FFF, '0, POS_BODY,
                                         MK_REQUEST));
      directed_rows.push_back(pinned_row(TAG_EOM, K_EOM, '0, '0, POS_END, MK_REQUEST));
      directed_rows.push_back(pinned_row(TAG_EOM, K_EOM, '0, '0, POS_LEAD, MK_UNKNOWN));
      directed_rows.push_back(pinned_row(TAG_UNKNOWN_LO, K_UNKNOWN, '0, '0, POS_BODY,
                                         MK_UNKNOWN));
      directed_rows.push_back(pinned_row(TAG_SHORT_STR_LO, K_STRING, '0, '0, POS_BODY,
                                         MK_UNKNOWN));
      directed_rows.push_back(plain_row(TAG_PTR));
      directed_rows.push_back(plain_row(8'h00));
      directed_rows.push_back(plain_row(TAG_HEAPPTR));
      directed_rows.push_back(plain_row(8'(PTR_BYTES + 1)));
      for (int i = 1; i <= PTR_BYTES + 1; i++)
         directed_rows.push_back(plain_row(8'(i * 8'h11)));
      directed_rows.push_back(pinned_row(TAG_EOM, K_EOM, '0, '0, POS_END, MK_UNKNOWN));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(1'b1, directed_rows[i]);
      hold_until_drained();

      for (int load = 0; load < 4; load++) begin
         idle_pct  = idle_load[load];
         stall_pct = stall_load[load];
         repeat (ITEMS_PER_LOAD) send_request(1'b0, no_row);
         hold_until_drained();
      end

      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d link bytes; checked %0d results (%0d payload bytes).",
               bytes_sent, results_checked, payload_seen);
      $display("Closed %0d messages; %0d of 19 value kinds seen.", messages_closed,
               $countones(kinds_seen));
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### tagged_value_stream_decoder.f
sv/tvsd_pkg.sv
sv/tvsd_front.sv
sv/tvsd_queue.sv
sv/tvsd_back.sv
sv/tagged_value_stream_decoder.sv
dv/tagged_value_stream_decoder_tb.sv
